// File: rtl/memory_self_test_sequencer_defines.svh
// Assertion macros used by the RTL of the memory self-test sequencer.
// They assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef MEMORY_SELF_TEST_SEQUENCER_DEFINES_SVH
`define MEMORY_SELF_TEST_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define MSTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MSTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define MSTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MSTS_ASSERT_ALWAYS(lbl, cond, msg)
`define MSTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define MSTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/msts_pkg.sv
`default_nettype none

package msts_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_ADDR = 2'd2,
    PH_CELL = 2'd3
  } phase_e;

  // Memory request codes.
  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Test status codes.
  localparam logic [1:0] STAT_PASS = 2'd0;
  localparam logic [1:0] STAT_DATA = 2'd1;
  localparam logic [1:0] STAT_ADDR = 2'd2;
  localparam logic [1:0] STAT_CELL = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE   = 2'd2;

  // Input item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [1:0]        request;
    logic [DATA_W-1:0] request_address;
    logic [DATA_W-1:0] write_data;
    logic              done_res;
    logic [1:0]        status;
    logic [DATA_W-1:0] error_bits;
    logic [DATA_W-1:0] error_offset;
    logic              last;
  } result_t;

  // Test patterns written to the word at the base address in the data phase and to each word in the cell phase.
  function automatic logic [DATA_W-1:0] test_pattern(input logic [1:0] idx);
    logic [DATA_W-1:0] pat;
    case (idx)
      2'd0:    pat = 32'h0000_0000;
      2'd1:    pat = 32'hFFFF_FFFF;
      2'd2:    pat = 32'h5555_5555;
      2'd3:    pat = 32'hAAAA_AAAA;
      default: pat = 32'h0000_0000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: rtl/msts_if.sv
`default_nettype none

// Input channel: start commands and read data returned from memory.
interface msts_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [msts_pkg::DATA_W-1:0]   read_data;

  modport source (output valid, output kind, output read_data, input ready);
  modport sink   (input valid, input kind, input read_data, output ready);
endinterface

// Result channel: memory requests and the final test report.
interface msts_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    request;
  logic [msts_pkg::DATA_W-1:0]   request_address;
  logic [msts_pkg::DATA_W-1:0]   write_data;
  logic                          done_res;
  logic [1:0]                    status;
  logic [msts_pkg::DATA_W-1:0]   error_bits;
  logic [msts_pkg::DATA_W-1:0]   error_offset;
  logic                          last;

  modport source (output valid, output request, output request_address, output write_data,
                  output done_res, output status, output error_bits, output error_offset,
                  output last, input ready);
  modport sink   (input valid, input request, input request_address, input write_data,
                  input done_res, input status, input error_bits, input error_offset,
                  input last, output ready);
endinterface

// Configuration write channel.
interface msts_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [msts_pkg::CFG_IDX_W-1:0]   index;
  logic [msts_pkg::DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/memory_self_test_sequencer.sv
// Memory self-test sequencer. The in_i channel takes start commands (kind 0)
// and words read back from the memory under test (kind 1). For each transfer
// the block emits zero, one or two results on out_o: read or write requests
// for the memory, and at the end a result with done_res set that carries the
// status, the mismatching bits or the failing byte offset. The last result of
// an input transfer has last set. cfg_i writes base_address, length_bytes and
// wide_bus; it is always ready and should be used between transfers only.
// Path: an input transfer lands in the input register, is decoded from there and
// is loaded into a two-entry result buffer once the buffer is empty or empties,
// and entry 0 of the buffer drives out_o.
// Throughput: with the sink always ready, one input transfer per cycle for
// items that cause at most one result; after an item that causes two, the next
// waits in the input register while the buffer drains one result per cycle.
// Reset clears the test state (idle), the buffer and the configuration
// registers to their defaults. If the sink stalls, results wait in the buffer
// and the input register fills, after which in_i.ready drops until space frees up.
`default_nettype none
`include "memory_self_test_sequencer_defines.svh"

module memory_self_test_sequencer #(
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  msts_in_if.sink           in_i,
  msts_cfg_if.sink          cfg_i,
  msts_out_if.source        out_o
);

  localparam int unsigned DW = msts_pkg::DATA_W;
  // Request addresses wrap at ADDR_WIDTH bits; only the low 32 bits go out.
  localparam logic [DW-1:0] AddrMask =
    (ADDR_WIDTH >= DW) ? {DW{1'b1}} : DW'((64'd1 << ADDR_WIDTH) - 64'd1);

  // Configuration registers.
  logic [DW-1:0] base_q;
  logic [DW-1:0] length_q;
  logic          wide_q;

  // Test state.
  msts_pkg::phase_e phase_q, phase_d;
  logic [1:0]       pat_q, pat_d;
  logic             await_q, await_d;
  logic [DW-1:0]    off_q, off_d;
  logic [DW-1:0]    saved_q, saved_d;
  logic             saved_we;

  // Input register.
  logic          in_vld_q;
  logic          kind_q;
  logic [DW-1:0] rdata_q;

  // Two-entry result buffer; entry 0 drives the output.
  msts_pkg::result_t res_q [2];
  logic [1:0]        cnt_q;
  msts_pkg::result_t res0_d, res1_d;
  logic [1:0]        nres_d;

  logic out_fire;
  logic load_go;

  assign cfg_i.ready = 1'b1;

  assign out_fire  = out_o.valid && out_o.ready;
  // The buffered item moves on when the buffer is empty or empties this cycle.
  assign load_go   = in_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire));
  assign in_i.ready = !in_vld_q || load_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      length_q <= 32'd8388608;
      wide_q   <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        msts_pkg::CFG_BASE:   base_q   <= cfg_i.data;
        msts_pkg::CFG_LENGTH: length_q <= cfg_i.data;
        msts_pkg::CFG_WIDE:   wide_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Decode of one item: all read-data comparisons use the low bus-width bits only.
  logic [DW-1:0] bus_mask;
  logic [2:0]    word_bytes;
  logic [DW-1:0] data_m;
  logic [DW-1:0] eff_off;
  logic [DW-1:0] cur_addr;
  logic [DW-1:0] zero_addr;
  logic [DW:0]   next_off;
  logic [DW-1:0] next_addr;
  logic          next_in_range;
  logic [DW-1:0] exp_cur;
  logic [DW-1:0] exp_first;
  logic [DW-1:0] exp_step;
  logic [1:0]    pat_inc;
  logic [DW-1:0] restore_data;

  always_comb begin
    bus_mask      = wide_q ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    word_bytes    = wide_q ? 3'd4 : 3'd2;
    data_m        = rdata_q & bus_mask;
    eff_off       = (phase_q == msts_pkg::PH_DATA) ? '0 : off_q;
    cur_addr      = (base_q + eff_off) & AddrMask;
    zero_addr     = base_q & AddrMask;
    next_off      = {1'b0, off_q} + {{(DW-2){1'b0}}, word_bytes};
    next_addr     = (base_q + next_off[DW-1:0]) & AddrMask;
    next_in_range = next_off < {1'b0, length_q};
    pat_inc       = pat_q + 2'd1;
    restore_data  = saved_q & bus_mask;
    if (phase_q == msts_pkg::PH_ADDR) begin
      exp_cur   = off_q & bus_mask;
      exp_first = off_q & bus_mask;
      exp_step  = off_q & bus_mask;
    end else begin
      exp_cur   = msts_pkg::test_pattern(pat_q) & bus_mask;
      exp_first = msts_pkg::test_pattern(2'd0) & bus_mask;
      exp_step  = msts_pkg::test_pattern(pat_inc) & bus_mask;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    pat_d    = pat_q;
    await_d  = await_q;
    off_d    = off_q;
    saved_d  = data_m;
    saved_we = 1'b0;
    res0_d   = '0;
    res1_d   = '0;
    nres_d   = 2'd0;

    if (kind_q == msts_pkg::KIND_START) begin
      // A start always restarts from the data phase.
      phase_d                = msts_pkg::PH_DATA;
      pat_d                  = 2'd0;
      await_d                = 1'b0;
      off_d                  = '0;
      res0_d.request         = msts_pkg::REQ_READ;
      res0_d.request_address = zero_addr;
      res0_d.last            = 1'b1;
      nres_d                 = 2'd1;
    end else if (phase_q == msts_pkg::PH_IDLE) begin
      nres_d = 2'd0;
    end else begin
      nres_d                 = 2'd2;
      res0_d.request         = msts_pkg::REQ_WRITE;
      res0_d.request_address = cur_addr;
      res1_d.last            = 1'b1;
      if (phase_q == msts_pkg::PH_DATA) begin
        off_d = '0;
      end
      if (!await_q) begin
        // This is the saved word; write the first expected value and read it back.
        saved_we               = 1'b1;
        await_d                = 1'b1;
        pat_d                  = 2'd0;
        res0_d.write_data      = exp_first;
        res1_d.request         = msts_pkg::REQ_READ;
        res1_d.request_address = cur_addr;
      end else if (data_m != exp_cur) begin
        // Mismatch: restore the word and report.
        res0_d.write_data = restore_data;
        res1_d.done_res   = 1'b1;
        if (phase_q == msts_pkg::PH_ADDR) begin
          res1_d.status       = msts_pkg::STAT_ADDR;
          res1_d.error_offset = off_q;
        end else begin
          res1_d.status     = (phase_q == msts_pkg::PH_DATA) ? msts_pkg::STAT_DATA
                                                             : msts_pkg::STAT_CELL;
          res1_d.error_bits = (data_m ^ exp_cur) & bus_mask;
        end
        phase_d = msts_pkg::PH_IDLE;
        await_d = 1'b0;
      end else if ((phase_q != msts_pkg::PH_ADDR) && (pat_q != 2'd3)) begin
        pat_d                  = pat_inc;
        res0_d.write_data      = exp_step;
        res1_d.request         = msts_pkg::REQ_READ;
        res1_d.request_address = cur_addr;
      end else begin
        // The word passed: restore it and move to the next word or phase.
        res0_d.write_data = restore_data;
        await_d           = 1'b0;
        pat_d             = 2'd0;
        if (phase_q == msts_pkg::PH_DATA) begin
          phase_d                = msts_pkg::PH_ADDR;
          off_d                  = '0;
          res1_d.request         = msts_pkg::REQ_READ;
          res1_d.request_address = zero_addr;
        end else if (next_in_range) begin
          off_d                  = next_off[DW-1:0];
          res1_d.request         = msts_pkg::REQ_READ;
          res1_d.request_address = next_addr;
        end else if (phase_q == msts_pkg::PH_ADDR) begin
          phase_d                = msts_pkg::PH_CELL;
          off_d                  = '0;
          res1_d.request         = msts_pkg::REQ_READ;
          res1_d.request_address = zero_addr;
        end else begin
          phase_d         = msts_pkg::PH_IDLE;
          off_d           = '0;
          res1_d.done_res = 1'b1;
          res1_d.status   = msts_pkg::STAT_PASS;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
      phase_q  <= msts_pkg::PH_IDLE;
      pat_q    <= 2'd0;
      await_q  <= 1'b0;
      off_q    <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (load_go) begin
        in_vld_q <= 1'b0;
      end
      if (load_go) begin
        cnt_q   <= nres_d;
        phase_q <= phase_d;
        pat_q   <= pat_d;
        await_q <= await_d;
        off_q   <= off_d;
      end else if (out_fire) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q  <= in_i.kind;
      rdata_q <= in_i.read_data;
    end
    if (load_go && saved_we) begin
      saved_q <= saved_d;
    end
    if (load_go) begin
      res_q[0] <= res0_d;
      res_q[1] <= res1_d;
    end else if (out_fire) begin
      res_q[0] <= res_q[1];
    end
  end

  assign out_o.valid           = (cnt_q != 2'd0);
  assign out_o.request         = res_q[0].request;
  assign out_o.request_address = res_q[0].request_address;
  assign out_o.write_data      = res_q[0].write_data;
  assign out_o.done_res        = res_q[0].done_res;
  assign out_o.status          = res_q[0].status;
  assign out_o.error_bits      = res_q[0].error_bits;
  assign out_o.error_offset    = res_q[0].error_offset;
  assign out_o.last            = res_q[0].last;

  // A final report never carries a memory request.
  `MSTS_ASSERT_IMPL(a_done_no_req, out_o.valid && out_o.done_res, out_o.request == msts_pkg::REQ_NONE, "done result carries a request")
  // Producing a final report leaves the sequencer idle.
  `MSTS_ASSERT_NEXT(a_done_idle, load_go && (nres_d == 2'd2) && res1_d.done_res, phase_q == msts_pkg::PH_IDLE, "report issued but test still running")
  // With two results buffered, the one in front is never the last of its item.
  `MSTS_ASSERT_IMPL(a_front_not_last, cnt_q == 2'd2, !res_q[0].last, "first of two buffered results marked last")
  // A pattern step beyond the first only happens while waiting for a readback.
  `MSTS_ASSERT_IMPL(a_pat_await, (pat_q != 2'd0) && (phase_q != msts_pkg::PH_IDLE), await_q, "pattern advanced without pending readback")

endmodule

`default_nettype wire
